// ===== hw/rtl/cfgrc_pkg.sv =====
// ----------------------------------------------------------------------------
// cfgrc_pkg: shared types and constants of the config record checker
// Header layout, FNV-1a constants, status codes and the stage record that
// travels from the parser to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package cfgrc_pkg;

  // Record geometry
  localparam int unsigned MaxRecordBytes = 256;
  localparam int unsigned PosW           = 9;
  localparam logic [PosW-1:0] HdrBytes   = PosW'(12);

  // FNV-1a 32
  localparam logic [31:0] FnvBasis = 32'h811C_9DC5;
  localparam logic [31:0] FnvPrime = 32'd16777619;

  // Configuration register indexes and reset values
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgExpectedLength = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgRecordMagic    = 1'b1;
  localparam logic [7:0]  ExpectedLengthRst = 8'd1;
  localparam logic [31:0] RecordMagicRst    = 32'h5355_4243;

  typedef enum logic [1:0] {
    StOk          = 2'd0,
    StBadMagic    = 2'd1,
    StBadLength   = 2'd2,
    StBadChecksum = 2'd3
  } status_e;

  // Payload request after the parse stage
  typedef struct packed {
    logic [7:0]  payload;
    logic        last;
    status_e     pre_status;  // status decided without the hash
    logic        check_hash;  // header checks passed, hash decides
    logic [31:0] hash;
    logic [31:0] checksum;
  } item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cfgrc_parse.sv =====
// ----------------------------------------------------------------------------
// cfgrc_parse: header capture and FNV-1a hashing
// Tracks the byte position, captures the little-endian header words and
// folds each payload byte into the running hash.
// ----------------------------------------------------------------------------
`default_nettype none

module cfgrc_parse import cfgrc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [7:0]  record_byte_i,
  input  wire logic        first_of_record_i,
  input  wire logic [7:0]  expected_length_i,
  input  wire logic [31:0] record_magic_i,
  output logic             emit_o,
  output item_t            item_o
);

  logic [PosW-1:0] byte_position_q, byte_position_d;
  logic [31:0]     magic_q, magic_d;
  logic [31:0]     length_q, length_d;
  logic [31:0]     checksum_q, checksum_d;
  logic [31:0]     hash_q, hash_d;

  logic [PosW-1:0] pos;
  logic [PosW-1:0] end_pos;
  logic [31:0]     hash_cur;
  logic [31:0]     hash_new;
  logic            active;
  logic            in_payload;
  logic [4:0]      lane_sh;
  logic [31:0]     lane_mask;
  logic [31:0]     lane_data;

  // Current position and hash, a start mark restarts both
  assign pos      = first_of_record_i ? '0 : byte_position_q;
  assign hash_cur = first_of_record_i ? FnvBasis : hash_q;
  assign end_pos  = HdrBytes + PosW'(expected_length_i);
  assign active   = pos < end_pos;
  assign in_payload = active && (pos >= HdrBytes);
  assign hash_new = (hash_cur ^ {24'd0, record_byte_i}) * FnvPrime;

  // Byte lane within a header word
  assign lane_sh   = {pos[1:0], 3'b000};
  assign lane_mask = ~(32'hFF << lane_sh);
  assign lane_data = {24'd0, record_byte_i} << lane_sh;

  // Next state
  always_comb begin
    byte_position_d = byte_position_q;
    magic_d         = magic_q;
    length_d        = length_q;
    checksum_d      = checksum_q;
    hash_d          = hash_q;
    if (accept_i) begin
      byte_position_d = pos;
      hash_d          = hash_cur;
      if (active) begin
        byte_position_d = pos + PosW'(1);
        if (in_payload) begin
          hash_d = hash_new;
        end else begin
          case (pos[3:2])
            2'd0:    magic_d    = (magic_q & lane_mask) | lane_data;
            2'd1:    length_d   = (length_q & lane_mask) | lane_data;
            default: checksum_d = (checksum_q & lane_mask) | lane_data;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_position_q <= '0;
      magic_q         <= '0;
      length_q        <= '0;
      checksum_q      <= '0;
      hash_q          <= FnvBasis;
    end else begin
      byte_position_q <= byte_position_d;
      magic_q         <= magic_d;
      length_q        <= length_d;
      checksum_q      <= checksum_d;
      hash_q          <= hash_d;
    end
  end

  // Payload request and header checks in priority order
  always_comb begin
    emit_o            = accept_i && in_payload;
    item_o.payload    = record_byte_i;
    item_o.last       = (pos + PosW'(1)) == end_pos;
    item_o.hash       = hash_new;
    item_o.checksum   = checksum_q;
    item_o.check_hash = 1'b0;
    if (int'(end_pos) > MaxRecordBytes) begin
      item_o.pre_status = StBadLength;
    end else if (magic_q != record_magic_i) begin
      item_o.pre_status = StBadMagic;
    end else if (length_q != {24'd0, expected_length_i}) begin
      item_o.pre_status = StBadLength;
    end else begin
      item_o.pre_status = StOk;
      item_o.check_hash = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/config_record_checker.sv =====
// ----------------------------------------------------------------------------
// config_record_checker: stored settings record checker
// Parses a 12-byte header, hashes the payload with FNV-1a 32 and reports
// the record status on the final payload byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one record byte per request, first_of_record_i restarts
//   parsing at header byte zero. Header bytes and bytes after the record end
//   produce no output. Each payload byte gives one output request carrying
//   the byte; the final one has last_of_record_o set and record_status_o
//   valid (ok, bad magic, length mismatch, checksum mismatch).
//   Configuration: cfg_we_i writes cfg_wdata_i into the register chosen by
//   cfg_index_i (expected length, record magic); write only while idle.
//   Pipeline: an accepted byte passes the parse/hash stage register, then
//   the status compare into the output register.
//   Throughput: one byte per cycle while in_stall_o is low; the hash update
//   (one xor and one constant multiply) is combinational.
//   Reset: position and header words clear, hash returns to the FNV offset
//   basis, registers return to their defaults, no output is pending.
//   Stall: a valid output request holds while out_stall_i is high; a payload
//   request already in the parse stage waits and in_stall_o rises at once,
//   with the parse stage empty bytes are taken until one payload byte fills it.
// ----------------------------------------------------------------------------
`default_nettype none

module config_record_checker import cfgrc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration write port
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]        cfg_wdata_i,
  // input channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         record_byte_i,
  input  wire logic               first_of_record_i,
  // output channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [7:0]              payload_byte_o,
  output logic                    last_of_record_o,
  output logic [1:0]              record_status_o
);

  logic [7:0]  expected_length_q;
  logic [31:0] record_magic_q;

  logic        accept;
  logic        emit;
  item_t       item;

  logic        s1_valid_q, s1_valid_d;
  item_t       s1_q;
  logic        s1_move;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q;
  logic        out_last_q;
  status_e     out_status_q, out_status_d;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_length_q <= ExpectedLengthRst;
      record_magic_q    <= RecordMagicRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgExpectedLength: expected_length_q <= cfg_wdata_i[7:0];
        CfgRecordMagic:    record_magic_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake
  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign accept     = in_valid_i && !in_stall_o;

  cfgrc_parse u_parse (
    .clk_i,
    .rst_ni,
    .accept_i          (accept),
    .record_byte_i,
    .first_of_record_i,
    .expected_length_i (expected_length_q),
    .record_magic_i    (record_magic_q),
    .emit_o            (emit),
    .item_o            (item)
  );

  // Parse stage register
  assign s1_valid_d = (s1_valid_q && !s1_move) || emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s1_q <= item;
    end
  end

  // Final status: hash compare only when the header checks passed
  always_comb begin
    out_status_d = StOk;
    if (s1_q.last) begin
      if (!s1_q.check_hash) begin
        out_status_d = s1_q.pre_status;
      end else if (s1_q.hash != s1_q.checksum) begin
        out_status_d = StBadChecksum;
      end
    end
  end

  // Output register
  assign out_valid_d = (out_valid_q && out_stall_i) || s1_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_byte_q   <= s1_q.payload;
      out_last_q   <= s1_q.last;
      out_status_q <= out_status_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign payload_byte_o   = out_byte_q;
  assign last_of_record_o = out_last_q;
  assign record_status_o  = out_status_q;

endmodule

`default_nettype wire

// ===== hw/rtl/cfgrc_checker.sv =====
// ----------------------------------------------------------------------------
// cfgrc_checker: port-level assertions for config_record_checker
// Watches the channels of the top level and is bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

module cfgrc_checker import cfgrc_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic [7:0]         record_byte_i,
  input wire logic               first_of_record_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [7:0]         payload_byte_o,
  input wire logic               last_of_record_o,
  input wire logic [1:0]         record_status_o
);

  // Stalled input request holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(record_byte_i) &&
      $stable(first_of_record_i))
    else $error("stalled input request changed");

  // Stalled output request holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(payload_byte_o) &&
      $stable(last_of_record_o) && $stable(record_status_o))
    else $error("stalled output request changed");

  // Status only reported on the final payload byte
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_record_o |-> record_status_o == StOk)
    else $error("status set on a non-final byte");

  // A new output request rises only after an input accept has passed the parse stage register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("output request without a matching input accept");

endmodule

bind config_record_checker cfgrc_checker u_cfgrc_checker (.*);

`default_nettype wire
